FILE: rtl/tmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared widths, constants and controller/datapath interface types for the
// trimmed mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 24;
  localparam int CNT_W       = 8;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  MAX_SAMPLES = CNT_W'(255);
  localparam logic [CNT_W-1:0]  TRIM_MIN    = CNT_W'(3);
  localparam logic [CNT_W-1:0]  TRIM_DROP   = CNT_W'(2);
  localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_ACC,
    S_TRIM,
    S_ABS,
    S_DIV,
    S_DONE
  } tmf_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc;   // fold the accepted sample into the set
    logic trim;  // form trimmed sum, latch divisor, clear the set
    logic absv;  // take magnitude and sign of the trimmed sum
    logic step;  // one restoring division step
    logic load;  // load the output register
  } tmf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic few;       // current set holds fewer than three samples
    logic div_last;  // final division step in progress
  } tmf_sts_t;

endpackage : tmf_pkg
`default_nettype wire

FILE: rtl/tmf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_ctrl
// Sequencer for the trimmed mean filter: accepts samples, walks the trim and
// division steps at the end of a set and owns the output valid flag.
// ----------------------------------------------------------------------------
module tmf_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  input  wire                in_tlast,
  output logic               in_tready,
  input  wire                out_tready,
  output logic               out_tvalid,
  input  tmf_pkg::tmf_sts_t  sts,
  output tmf_pkg::tmf_cmd_t  cmd
);
  import tmf_pkg::*;

  tmf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_ACC: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.acc = 1'b1;
          if (in_tlast) state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = sts.few ? S_DONE : S_ABS;
      end
      S_ABS: begin
        cmd.absv  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  // Hold the result until taken, raise it on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("output loaded over an untaken result");

  a_last_trims : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == S_TRIM))
    else $error("final sample did not close the set");

  a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (!in_tready && !cmd.load))
    else $error("sample or load during division");

endmodule : tmf_ctrl
`default_nettype wire

FILE: rtl/tmf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_dp
// Datapath of the trimmed mean filter: running sum, extremes and count,
// trimmed sum, bit-serial restoring divider and output register.
// ----------------------------------------------------------------------------
module tmf_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  tmf_pkg::tmf_cmd_t                  cmd,
  output tmf_pkg::tmf_sts_t                  sts,
  input  wire signed [tmf_pkg::SAMPLE_W-1:0] sample,
  output logic signed [tmf_pkg::SAMPLE_W-1:0] mean,
  output logic                               too_few
);
  import tmf_pkg::*;

  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SUM_W-1:0]    diff_r, diff_nxt;
  logic [CNT_W-1:0]           divisor_r, divisor_nxt;
  logic                       few_r, few_nxt;
  logic                       neg_r, neg_nxt;
  logic [SUM_W-1:0]           mag_r, mag_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic signed [SAMPLE_W-1:0] mean_r, mean_nxt;
  logic                       too_few_r, too_few_nxt;
  logic [CNT_W:0]             rem_sh;
  logic [CNT_W:0]             rem_sub;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    max_r     <= max_nxt;
    min_r     <= min_nxt;
    diff_r    <= diff_nxt;
    divisor_r <= divisor_nxt;
    few_r     <= few_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    rem_r     <= rem_nxt;
    mean_r    <= mean_nxt;
    too_few_r <= too_few_nxt;
  end

  // Shift-in partial remainder and trial subtraction
  assign rem_sh  = {rem_r, mag_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  always_comb begin
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    max_nxt     = max_r;
    min_nxt     = min_r;
    diff_nxt    = diff_r;
    divisor_nxt = divisor_r;
    few_nxt     = few_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    mean_nxt    = mean_r;
    too_few_nxt = too_few_r;

    // Accumulate; drop samples once the count is full
    if (cmd.acc && (cnt_r < MAX_SAMPLES)) begin
      if (cnt_r == '0) begin
        max_nxt = sample;
        min_nxt = sample;
      end else begin
        if (sample > max_r) max_nxt = sample;
        if (sample < min_r) min_nxt = sample;
      end
      sum_nxt = sum_r + SUM_W'(sample);
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    // Remove one largest and one smallest, then clear the set
    if (cmd.trim) begin
      diff_nxt    = sum_r - SUM_W'(max_r) - SUM_W'(min_r);
      divisor_nxt = cnt_r - TRIM_DROP;
      few_nxt     = (cnt_r < TRIM_MIN);
      sum_nxt     = '0;
      cnt_nxt     = '0;
    end

    // Split into sign and magnitude for truncating division
    if (cmd.absv) begin
      neg_nxt  = diff_r[SUM_W-1];
      mag_nxt  = diff_r[SUM_W-1] ? SUM_W'(-diff_r) : SUM_W'(diff_r);
      rem_nxt  = '0;
      step_nxt = '0;
    end

    // One quotient bit per step, quotient shifts into the dividend register
    if (cmd.step) begin
      if (!rem_sub[CNT_W]) begin
        rem_nxt = rem_sub[CNT_W-1:0];
        mag_nxt = {mag_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CNT_W-1:0];
        mag_nxt = {mag_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
    end

    // Restore the sign and load the result
    if (cmd.load) begin
      too_few_nxt = few_r;
      if (few_r)      mean_nxt = '0;
      else if (neg_r) mean_nxt = -$signed(mag_r[SAMPLE_W-1:0]);
      else            mean_nxt = $signed(mag_r[SAMPLE_W-1:0]);
    end
  end

  assign sts.few      = (cnt_r < TRIM_MIN);
  assign sts.div_last = (step_r == LAST_STEP);
  assign mean         = mean_r;
  assign too_few      = too_few_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_SAMPLES)
    else $error("sample count beyond limit");

  a_step_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (step_r <= LAST_STEP))
    else $error("division step count overrun");

  a_trim_clears : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trim |=> (cnt_r == '0 && sum_r == '0))
    else $error("set state not cleared after trim");

endmodule : tmf_dp
`default_nettype wire

FILE: rtl/trimmed_mean_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sample per cycle while a set is open.
// Closing a set: the final sample is followed by a trim state, a sign state
// and 24 steps of the bit-serial divider, then the output load; a set of
// fewer than 3 samples goes from the trim state straight to the output load.
// Input is stalled over that span; a held result stalls only the next close.
// Synchronous active-low reset clears the open set and the output valid flag.
// ----------------------------------------------------------------------------
// trimmed_mean_filter
// Mean of a set of signed samples with one largest and one smallest removed,
// truncated toward zero.
// ----------------------------------------------------------------------------
module trimmed_mean_filter (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [15:0] in_tdata,   // [15:0] sample
  input  wire        in_tlast,
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata, // [15:0] mean
  output logic       out_tuser   // [0] too_few
);
  import tmf_pkg::*;

  tmf_cmd_t cmd;
  tmf_sts_t sts;
  logic signed [SAMPLE_W-1:0] mean;

  // Sequencer
  tmf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic
  tmf_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .sample  ($signed(in_tdata)),
    .mean    (mean),
    .too_few (out_tuser)
  );

  assign out_tdata = mean;

endmodule : trimmed_mean_filter
`default_nettype wire

FILE: dv/tb_trimmed_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_mean_filter
// Self-checking bench for the trimmed mean filter. A short table of directed
// sets (extremes, short sets, truncation toward zero) is followed by random
// sets of mixed length, some long enough to saturate the sample count. Each
// accepted sample is folded into a local model of the filter; closed sets
// queue an expected mean that is compared with every output transaction.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_filter;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct packed {
    logic signed [15:0] mean;
    logic               few;
  } mean_exp_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               fin;
    logic               typed;
    mean_exp_t          result;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] sample
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] mean
  logic        out_tuser;  // [0] too_few

  // Local copy of the open set
  int                 set_sum;
  logic signed [15:0] set_hi;
  logic signed [15:0] set_lo;
  int                 set_cnt;

  mean_exp_t mean_q[$];
  stim_row_t stim_rows[$];
  int        fail_cnt;
  int        cycle_cnt;

  trimmed_mean_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Fold one sample into the set; close the set on the final sample
  function automatic void fold_sample(input logic signed [15:0] s, input logic fin,
                                      output bit emit, output mean_exp_t res);
    int rest;
    int divisor;
    emit = 1'b0;
    res  = '0;
    if (set_cnt < int'(tmf_pkg::MAX_SAMPLES)) begin
      if (set_cnt == 0) begin
        set_hi = s;
        set_lo = s;
      end else begin
        if (s > set_hi) set_hi = s;
        if (s < set_lo) set_lo = s;
      end
      set_sum = set_sum + int'(s);
      set_cnt = set_cnt + 1;
    end
    if (fin) begin
      emit = 1'b1;
      if (set_cnt < int'(tmf_pkg::TRIM_MIN)) begin
        res.few  = 1'b1;
        res.mean = '0;
      end else begin
        rest     = set_sum - int'(set_hi) - int'(set_lo);
        divisor  = set_cnt - int'(tmf_pkg::TRIM_DROP);
        res.mean = 16'(rest / divisor);
        res.few  = 1'b0;
      end
      set_sum = 0;
      set_hi  = '0;
      set_lo  = '0;
      set_cnt = 0;
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len(input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, long_max);
  endfunction

  // Extremes, small values around zero, or the full range
  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'sh7fff;
    if (r < 10) return 16'sh8000;
    if (r < 40) return 16'($signed($urandom_range(0, 16)) - 8);
    return 16'($urandom());
  endfunction

  function automatic stim_row_t row(input int s, input logic fin, input logic typed,
                                    input int m, input logic few);
    stim_row_t r;
    r.sample      = 16'(s);
    r.fin         = fin;
    r.typed       = typed;
    r.result.mean = 16'(m);
    r.result.few  = few;
    return r;
  endfunction

  // Present one sample, hold it until accepted, then predict; entered at a falling edge
  task automatic send_sample(input logic signed [15:0] s, input logic fin, input int gap,
                             input logic typed, input mean_exp_t typed_res);
    bit        emit;
    mean_exp_t res;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    fold_sample(s, fin, emit, res);
    if (emit) mean_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Hold the sender until every queued result has drained
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (mean_q.size() != 0);
  endtask

  // Receiver back-pressure
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin : ready_loop
      int run;
      int stall;
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      stall = gap_len(60);
      out_tready <= 1'b1;
      repeat (run) @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mean_q.size() == 0) begin
        fail_cnt = fail_cnt + 1;
        $display("%0t: unexpected result mean=%0d too_few=%0b", $realtime,
                 $signed(out_tdata), out_tuser);
      end else begin : compare_blk
        mean_exp_t e;
        e = mean_q.pop_front();
        if (out_tdata !== e.mean) begin
          fail_cnt = fail_cnt + 1;
          $display("%0t: mean expected %0d actual %0d", $realtime, e.mean,
                   $signed(out_tdata));
        end
        if (out_tuser !== e.few) begin
          fail_cnt = fail_cnt + 1;
          $display("%0t: too_few expected %0b actual %0b", $realtime, e.few, out_tuser);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin : main_seq
    int sent;
    int set_len;
    int set_idx;
    int r;
    bit burst;
    fail_cnt  = 0;
    cycle_cnt = 0;
    set_sum   = 0;
    set_hi    = '0;
    set_lo    = '0;
    set_cnt   = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;

    // Directed sets: short sets, extremes, truncation toward zero
    stim_rows.push_back(row( 32767, 1'b1, 1'b1, 0, 1'b1));
    stim_rows.push_back(row(-32768, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row( 32767, 1'b1, 1'b1, 0, 1'b1));
    stim_rows.push_back(row( 32767, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row( 32767, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row( 32767, 1'b1, 1'b1, 32767, 1'b0));
    stim_rows.push_back(row(-32768, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(-32768, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(-32768, 1'b1, 1'b1, -32768, 1'b0));
    stim_rows.push_back(row(     0, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(     0, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(     0, 1'b1, 1'b1, 0, 1'b0));
    stim_rows.push_back(row(    -4, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(     1, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(     2, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(    -9, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(    10, 1'b1, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(    10, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(    -1, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(    -2, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(    -3, 1'b1, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(-32768, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row( 32767, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row(-32768, 1'b0, 1'b0, 0, 1'b0));
    stim_rows.push_back(row( 32767, 1'b1, 1'b0, 0, 1'b0));

    // Reset
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      send_sample(stim_rows[i].sample, stim_rows[i].fin, gap_len(40), stim_rows[i].typed,
                  stim_rows[i].result);
    end
    drain_results();

    // Random sets; the first one overruns the sample count
    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (set_idx == 0)  set_len = 256;
      else if (r < 50)   set_len = $urandom_range(1, 6);
      else if (r < 85)   set_len = $urandom_range(7, 20);
      else if (r < 96)   set_len = $urandom_range(21, 80);
      else               set_len = $urandom_range(250, 300);
      // Keep the total close to the item budget
      if (set_len > RANDOM_ITEMS - sent) set_len = RANDOM_ITEMS - sent;
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        send_sample(pick_sample(), (k == set_len - 1), burst ? 0 : gap_len(40), 1'b0, '0);
      end
      sent = sent + set_len;
      // Let the pipe empty now and then
      if (set_idx == 3 || $urandom_range(0, 24) == 0) drain_results();
      set_idx = set_idx + 1;
    end
    in_tvalid <= 1'b0;

    // Drain
    while (mean_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tmf_pkg.sv
rtl/tmf_ctrl.sv
rtl/tmf_dp.sv
rtl/trimmed_mean_filter.sv
dv/tb_trimmed_mean_filter.sv
